// File: rtl/core/nfxlms_pkg.sv
`timescale 1ns / 1ps
package nfxlms_pkg;

  localparam int TAPS   = 64;
  localparam int IDX_W  = $clog2(TAPS);
  localparam int LEN_W  = IDX_W + 1;

  localparam int REF_W  = 16;
  localparam int ERR_W  = 16;
  localparam int SEC_W  = 24;
  localparam int FILT_W = 24;
  localparam int W_W    = 32;
  localparam int Y_W    = 16;
  localparam int STEP_W = 32;
  localparam int TUSE_W = 7;

  // fractional bits dropped when forming outputs
  localparam int Y_SHIFT = 24;
  localparam int F_SHIFT = 15;

  localparam int HIST_W  = FILT_W + REF_W;
  localparam int TAPR_W  = SEC_W + W_W;

  localparam int ACC_Y_W = REF_W + W_W + IDX_W;
  localparam int ACC_F_W = REF_W + SEC_W + IDX_W;
  localparam int SQ_W    = 2 * FILT_W - 1;
  localparam int POW_W   = SQ_W + IDX_W;

  localparam int A_W      = STEP_W + ERR_W;
  localparam int A_HALF   = A_W / 2;
  localparam int FMAG_W   = FILT_W;
  localparam int NUM_W    = A_W + FMAG_W;
  localparam int FRAC_SHIFT = 12;
  localparam int Q_W      = 41;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_PROC  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic REG_STEP = 1'b0;
  localparam logic REG_TAPS = 1'b1;

  localparam logic [STEP_W-1:0] STEP_RESET = 32'd429497;
  localparam logic [TUSE_W-1:0] TUSE_RESET = 7'd50;

endpackage

// File: rtl/core/normalized_fxlms_filter_unit.sv
`timescale 1ns / 1ps
// Normalized filtered-x LMS filter for active noise control.
// Input channel (in_valid_i/in_ready_o) takes one word per command: load a
// secondary-path tap, process a sample, or clear the adaptive state.
// A process word gives one result word on the output channel
// (out_valid_o/out_ready_i); load and clear give none.
// A process word shifts the reference history, then forms the anti-noise and
// filtered-x sums, then the filtered-x power, then updates each active tap
// whose filtered value and step-error product are nonzero; other taps stay.
// The per-tap division (one quotient bit per cycle) is the slow step;
// state lives in two one-port-read synchronous memories that are walked one
// entry at a time.
// One word is in work at a time; in_ready_o is high only while idle.
// The result sits in an output register, so the next word is taken while it
// waits; a stalled receiver holds a finished process word until it drains.
// After reset a clearing pass zeroes all memories before the first
// word is taken. Register writes on cfg_we_i take effect at once and belong
// to idle periods.
module normalized_fxlms_filter_unit
  import nfxlms_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [STEP_W-1:0]        cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               cmd_i,
  input  logic [IDX_W-1:0]         coeff_index_i,
  input  logic signed [SEC_W-1:0]  coeff_value_i,
  input  logic signed [REF_W-1:0]  ref_sample_i,
  input  logic signed [ERR_W-1:0]  err_sample_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [Y_W-1:0]    anti_noise_o,
  output logic                     saturated_o
);

  localparam logic [4:0] ST_INIT    = 5'd0;
  localparam logic [4:0] ST_IDLE    = 5'd1;
  localparam logic [4:0] ST_CLR     = 5'd2;
  localparam logic [4:0] ST_SH_RD   = 5'd3;
  localparam logic [4:0] ST_SH_WR   = 5'd4;
  localparam logic [4:0] ST_SH_HEAD = 5'd5;
  localparam logic [4:0] ST_MAC     = 5'd6;
  localparam logic [4:0] ST_MAC_END = 5'd7;
  localparam logic [4:0] ST_POW     = 5'd8;
  localparam logic [4:0] ST_POW_END = 5'd9;
  localparam logic [4:0] ST_U_RD    = 5'd10;
  localparam logic [4:0] ST_U_CHK   = 5'd11;
  localparam logic [4:0] ST_U_M1    = 5'd12;
  localparam logic [4:0] ST_U_M2    = 5'd13;
  localparam logic [4:0] ST_U_NUM   = 5'd14;
  localparam logic [4:0] ST_U_START = 5'd15;
  localparam logic [4:0] ST_U_DIV   = 5'd16;
  localparam logic [4:0] ST_DONE    = 5'd17;

  localparam int YR_W  = ACC_Y_W + 1;
  localparam int YSH_W = YR_W - Y_SHIFT;
  localparam int FR_W  = ACC_F_W + 1;
  localparam int FSH_W = FR_W - F_SHIFT;
  localparam int NW_W  = Q_W + 1;

  // memories: history rows {filt, ref}, tap rows {sec, w}
  logic [HIST_W-1:0] hist_mem [TAPS];
  logic [TAPR_W-1:0] tap_mem  [TAPS];
  logic [HIST_W-1:0] h_rdata_q;
  logic [TAPR_W-1:0] t_rdata_q;

  logic [IDX_W-1:0]  h_raddr, h_waddr, t_raddr, t_waddr;
  logic              h_we_ref, h_we_filt, t_we_w, t_we_sec;
  logic [REF_W-1:0]  h_wref;
  logic [FILT_W-1:0] h_wfilt;
  logic [W_W-1:0]    t_ww;
  logic [SEC_W-1:0]  t_wsec;

  always_ff @(posedge clk_i) begin
    if (h_we_ref) begin
      hist_mem[h_waddr][REF_W-1:0] <= h_wref;
    end
    if (h_we_filt) begin
      hist_mem[h_waddr][HIST_W-1:REF_W] <= h_wfilt;
    end
    h_rdata_q <= hist_mem[h_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (t_we_w) begin
      tap_mem[t_waddr][W_W-1:0] <= t_ww;
    end
    if (t_we_sec) begin
      tap_mem[t_waddr][TAPR_W-1:W_W] <= t_wsec;
    end
    t_rdata_q <= tap_mem[t_raddr];
  end

  logic signed [REF_W-1:0]  rd_ref;
  logic signed [FILT_W-1:0] rd_filt;
  logic signed [W_W-1:0]    rd_w;
  logic signed [SEC_W-1:0]  rd_sec;

  assign rd_ref  = h_rdata_q[REF_W-1:0];
  assign rd_filt = h_rdata_q[HIST_W-1:REF_W];
  assign rd_w    = t_rdata_q[W_W-1:0];
  assign rd_sec  = t_rdata_q[TAPR_W-1:W_W];

  // registers
  logic [4:0]          state_q, state_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [LEN_W-1:0]    len_q, len_d;
  logic [REF_W-1:0]    ref_q, ref_d;
  logic [ERR_W-1:0]    err_q, err_d;
  logic                rv_q, rv_d, pv_q, pv_d;
  logic [ACC_Y_W-1:0]  acc_y_q, acc_y_d;
  logic [ACC_F_W-1:0]  acc_f_q, acc_f_d;
  logic [POW_W-1:0]    pow_q, pow_d;
  logic [POW_W-1:0]    power_q, power_d;
  logic [REF_W+W_W-1:0]   prod_y_q, prod_y_d;
  logic [REF_W+SEC_W-1:0] prod_f_q, prod_f_d;
  logic [SQ_W-1:0]     sq_q, sq_d;
  logic [Y_W-1:0]      y_q, y_d;
  logic                sat_q, sat_d;
  logic [A_W-1:0]      a_q, a_d;
  logic [FILT_W-1:0]   f_q, f_d;
  logic [W_W-1:0]      w_q, w_d;
  logic [FMAG_W-1:0]   fmag_q, fmag_d;
  logic [A_HALF+FMAG_W-1:0] plo_q, plo_d, phi_q, phi_d;
  logic [NUM_W-1:0]    num_q, num_d;
  logic                out_valid_q, out_valid_d;
  logic [Y_W-1:0]      out_y_q, out_y_d;
  logic                out_sat_q, out_sat_d;
  logic [STEP_W-1:0]   step_q;
  logic [TUSE_W-1:0]   tuse_q;

  logic             div_start, div_done;
  logic [Q_W-1:0]   div_quot;

  nfxlms_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (power_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // combinational helpers
  logic [LEN_W-1:0]  len_c;
  logic              last;
  logic [YR_W-1:0]   y_sum;
  logic [YSH_W-1:0]  y_sh;
  logic              y_ovf;
  logic [FR_W-1:0]   f_sum;
  logic [FSH_W-1:0]  f_sh;
  logic              f_ovf;
  logic [FILT_W-1:0] fv_c;
  logic [ERR_W-1:0]  emag;
  logic signed [2*FILT_W-1:0] sq_full;
  logic [NW_W-1:0]   nw;
  logic              nw_ovf;
  logic [W_W-1:0]    nw_sat;

  always_comb begin
    if (tuse_q == '0) begin
      len_c = LEN_W'(1);
    end else if ({{(32 - TUSE_W){1'b0}}, tuse_q} > 32'(TAPS)) begin
      len_c = LEN_W'(TAPS);
    end else begin
      len_c = LEN_W'(tuse_q);
    end
  end

  assign last = ({1'b0, idx_q} == len_q - LEN_W'(1));

  // anti-noise: round half up, drop Q.24 fraction, saturate
  assign y_sum = {acc_y_q[ACC_Y_W-1], acc_y_q} + (YR_W'(1) << (Y_SHIFT - 1));
  assign y_sh  = y_sum[YR_W-1:Y_SHIFT];
  assign y_ovf = (y_sh[YSH_W-1:Y_W-1] != {(YSH_W - Y_W + 1){y_sh[YSH_W-1]}});

  assign f_sum = {acc_f_q[ACC_F_W-1], acc_f_q} + (FR_W'(1) << (F_SHIFT - 1));
  assign f_sh  = f_sum[FR_W-1:F_SHIFT];
  assign f_ovf = (f_sh[FSH_W-1:FILT_W-1] != {(FSH_W - FILT_W + 1){f_sh[FSH_W-1]}});
  assign fv_c  = f_ovf ? {f_sh[FSH_W-1], {(FILT_W - 1){~f_sh[FSH_W-1]}}}
                       : f_sh[FILT_W-1:0];

  assign emag    = err_q[ERR_W-1] ? (~err_q + ERR_W'(1)) : err_q;
  assign sq_full = rd_filt * rd_filt;

  // tap moves against the sign of err*filtered
  always_comb begin
    if (err_q[ERR_W-1] == f_q[FILT_W-1]) begin
      nw = {{(NW_W - W_W){w_q[W_W-1]}}, w_q} - {1'b0, div_quot};
    end else begin
      nw = {{(NW_W - W_W){w_q[W_W-1]}}, w_q} + {1'b0, div_quot};
    end
  end
  assign nw_ovf = (nw[NW_W-1:W_W-1] != {(NW_W - W_W + 1){nw[NW_W-1]}});
  assign nw_sat = nw_ovf ? {nw[NW_W-1], {(W_W - 1){~nw[NW_W-1]}}} : nw[W_W-1:0];

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    len_d       = len_q;
    ref_d       = ref_q;
    err_d       = err_q;
    acc_y_d     = acc_y_q;
    acc_f_d     = acc_f_q;
    pow_d       = pow_q;
    power_d     = power_q;
    y_d         = y_q;
    sat_d       = sat_q;
    a_d         = a_q;
    f_d         = f_q;
    w_d         = w_q;
    fmag_d      = fmag_q;
    plo_d       = plo_q;
    phi_d       = phi_q;
    num_d       = num_q;
    out_valid_d = out_valid_q;
    out_y_d     = out_y_q;
    out_sat_d   = out_sat_q;

    h_raddr   = idx_q;
    t_raddr   = idx_q;
    h_waddr   = idx_q;
    t_waddr   = idx_q;
    h_we_ref  = 1'b0;
    h_we_filt = 1'b0;
    t_we_w    = 1'b0;
    t_we_sec  = 1'b0;
    h_wref    = '0;
    h_wfilt   = '0;
    t_ww      = '0;
    t_wsec    = '0;
    div_start = 1'b0;

    // read -> product -> accumulate pipeline
    rv_d     = 1'b0;
    pv_d     = rv_q;
    prod_y_d = rd_ref * rd_w;
    prod_f_d = rd_ref * rd_sec;
    sq_d     = sq_full[SQ_W-1:0];
    if (pv_q) begin
      if (state_q == ST_MAC || state_q == ST_MAC_END) begin
        acc_y_d = acc_y_q + {{IDX_W{prod_y_q[REF_W+W_W-1]}}, prod_y_q};
        acc_f_d = acc_f_q + {{IDX_W{prod_f_q[REF_W+SEC_W-1]}}, prod_f_q};
      end else begin
        pow_d = pow_q + {{IDX_W{1'b0}}, sq_q};
      end
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_INIT, ST_CLR: begin
        h_we_ref  = 1'b1;
        h_we_filt = 1'b1;
        t_we_w    = 1'b1;
        t_we_sec  = (state_q == ST_INIT);
        idx_d     = idx_q + IDX_W'(1);
        if (idx_q == IDX_W'(TAPS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          case (cmd_i)
            CMD_LOAD: begin
              t_waddr  = coeff_index_i;
              t_we_sec = 1'b1;
              t_wsec   = coeff_value_i;
            end
            CMD_PROC: begin
              ref_d = ref_sample_i;
              err_d = err_sample_i;
              len_d = len_c;
              sat_d = 1'b0;
              idx_d = IDX_W'(len_c - LEN_W'(1));
              state_d = (len_c == LEN_W'(1)) ? ST_SH_HEAD : ST_SH_RD;
            end
            CMD_CLEAR: begin
              idx_d   = '0;
              state_d = ST_CLR;
            end
            default: ;
          endcase
        end
      end
      ST_SH_RD: begin
        h_raddr = idx_q - IDX_W'(1);
        state_d = ST_SH_WR;
      end
      ST_SH_WR: begin
        h_we_ref  = 1'b1;
        h_we_filt = 1'b1;
        h_wref    = rd_ref;
        h_wfilt   = rd_filt;
        if (idx_q == IDX_W'(1)) begin
          state_d = ST_SH_HEAD;
        end else begin
          idx_d   = idx_q - IDX_W'(1);
          state_d = ST_SH_RD;
        end
      end
      ST_SH_HEAD: begin
        h_waddr  = '0;
        h_we_ref = 1'b1;
        h_wref   = ref_q;
        idx_d    = '0;
        acc_y_d  = '0;
        acc_f_d  = '0;
        state_d  = ST_MAC;
      end
      ST_MAC: begin
        rv_d = 1'b1;
        if (last) begin
          state_d = ST_MAC_END;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_MAC_END: begin
        if (!rv_q && !pv_q) begin
          y_d   = y_ovf ? {y_sh[YSH_W-1], {(Y_W - 1){~y_sh[YSH_W-1]}}} : y_sh[Y_W-1:0];
          sat_d = sat_q | y_ovf | f_ovf;
          h_waddr   = '0;
          h_we_filt = 1'b1;
          h_wfilt   = fv_c;
          idx_d   = '0;
          pow_d   = '0;
          state_d = ST_POW;
        end
      end
      ST_POW: begin
        rv_d = 1'b1;
        if (last) begin
          state_d = ST_POW_END;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_POW_END: begin
        if (!rv_q && !pv_q) begin
          // empty line gets a floor of one lsb
          power_d = (pow_q == '0) ? POW_W'(1) : pow_q;
          a_d     = step_q * emag;
          idx_d   = '0;
          state_d = ST_U_RD;
        end
      end
      ST_U_RD: begin
        state_d = ST_U_CHK;
      end
      ST_U_CHK: begin
        f_d    = rd_filt;
        w_d    = rd_w;
        fmag_d = rd_filt[FILT_W-1] ? (~rd_filt + FILT_W'(1)) : rd_filt;
        if (rd_filt == '0 || a_q == '0) begin
          if (last) begin
            state_d = ST_DONE;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = ST_U_RD;
          end
        end else begin
          state_d = ST_U_M1;
        end
      end
      ST_U_M1: begin
        plo_d   = a_q[A_HALF-1:0] * fmag_q;
        state_d = ST_U_M2;
      end
      ST_U_M2: begin
        phi_d   = a_q[A_W-1:A_HALF] * fmag_q;
        state_d = ST_U_NUM;
      end
      ST_U_NUM: begin
        num_d   = {phi_q, {A_HALF{1'b0}}} + NUM_W'(plo_q);
        state_d = ST_U_START;
      end
      ST_U_START: begin
        div_start = 1'b1;
        state_d   = ST_U_DIV;
      end
      ST_U_DIV: begin
        if (div_done) begin
          t_we_w = 1'b1;
          t_ww   = nw_sat;
          sat_d  = sat_q | nw_ovf;
          if (last) begin
            state_d = ST_DONE;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = ST_U_RD;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_y_d     = y_q;
          out_sat_d   = sat_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      idx_q       <= '0;
      rv_q        <= 1'b0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
      step_q      <= STEP_RESET;
      tuse_q      <= TUSE_RESET;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      rv_q        <= rv_d;
      pv_q        <= pv_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_STEP: step_q <= cfg_wdata_i;
          REG_TAPS: tuse_q <= cfg_wdata_i[TUSE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    len_q    <= len_d;
    ref_q    <= ref_d;
    err_q    <= err_d;
    acc_y_q  <= acc_y_d;
    acc_f_q  <= acc_f_d;
    pow_q    <= pow_d;
    power_q  <= power_d;
    prod_y_q <= prod_y_d;
    prod_f_q <= prod_f_d;
    sq_q     <= sq_d;
    y_q      <= y_d;
    sat_q    <= sat_d;
    a_q      <= a_d;
    f_q      <= f_d;
    w_q      <= w_d;
    fmag_q   <= fmag_d;
    plo_q    <= plo_d;
    phi_q    <= phi_d;
    num_q    <= num_d;
    out_y_q  <= out_y_d;
    out_sat_q <= out_sat_d;
  end

  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign anti_noise_o = out_y_q;
  assign saturated_o  = out_sat_q;

endmodule

// File: rtl/core/nfxlms_divider.sv
`timescale 1ns / 1ps
module nfxlms_divider
  import nfxlms_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [POW_W-1:0] den_i,
  output logic             done_o,
  output logic [Q_W-1:0]   quot_o
);

  localparam int EXT_W = NUM_W + FRAC_SHIFT;
  localparam int HI_W  = EXT_W - Q_W;
  localparam int CNT_W = $clog2(Q_W + 1);
  localparam logic [Q_W-1:0] CAP = Q_W'(1) << (Q_W - 1);

  logic [EXT_W-1:0] ext;
  logic [HI_W-1:0]  hi;
  logic [POW_W:0]   trial;
  logic [POW_W:0]   diff;
  logic             ge;

  logic [POW_W-1:0] rem_q;
  logic [POW_W-1:0] den_q;
  logic [Q_W-1:0]   sh_q;
  logic [Q_W-1:0]   quo_q;
  logic             ovf_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  assign ext   = {num_i, {FRAC_SHIFT{1'b0}}};
  assign hi    = ext[EXT_W-1:Q_W];
  assign trial = {rem_q, sh_q[Q_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(Q_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= {{(POW_W - HI_W){1'b0}}, hi};
      ovf_q <= ({{(POW_W - HI_W){1'b0}}, hi} >= den_i);
      sh_q  <= ext[Q_W-1:0];
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[POW_W-1:0] : trial[POW_W-1:0];
      quo_q <= {quo_q[Q_W-2:0], ge};
      sh_q  <= {sh_q[Q_W-2:0], 1'b0};
    end
  end

  // quotient at or above the cap saturates
  assign quot_o = (ovf_q || (quo_q > CAP)) ? CAP : quo_q;
  assign done_o = done_q;

endmodule
